>>> rtl/ctc_pkg.sv
package ctc_pkg;

	localparam int DEF_MAX_COLUMNS = 8;
	localparam int DEF_MAX_ROWS    = 8;
	localparam int KEY_SLOTS       = 8;
	localparam int KEY_W           = 64;
	localparam int KEYLEN_W        = 4;
	localparam int CFG_DATA_W      = KEY_W;
	localparam int CFG_INDEX_W     = 1;

	localparam logic [7:0] PAD_BYTE = 8'h20;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CHARS  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_TRUNC = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_in;
		logic       last_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
		logic [1:0] status;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic setup;
		logic rank;
		logic divide;
		logic issue;
		logic load;
		logic empty;
	} ctc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rank_done;
		logic div_done;
		logic rows_zero;
		logic out_last;
	} ctc_sts_t;

endpackage

>>> rtl/ctc_ram.sv
module ctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/ctc_ctrl.sv
module ctc_ctrl
	import ctc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last_in,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output ctc_cmd_t cmd,
	input  ctc_sts_t sts
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SETUP  = 8'b0000_0010,
		ST_RANK   = 8'b0000_0100,
		ST_DIVIDE = 8'b0000_1000,
		ST_ISSUE  = 8'b0001_0000,
		ST_LOAD   = 8'b0010_0000,
		ST_SEND   = 8'b0100_0000,
		ST_EMPTY  = 8'b1000_0000
	} ctc_state_t;

	ctc_state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				if (in_valid && last_in) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_RANK;
			end
			ST_RANK: begin
				cmd.rank = 1'b1;
				if (sts.rank_done) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.divide = 1'b1;
				if (sts.div_done) begin
					state_d = sts.rows_zero ? ST_EMPTY : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_SEND;
			end
			ST_EMPTY: begin
				cmd.empty = 1'b1;
				state_d   = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (sts.out_last) begin
						state_d = ST_IDLE;
					end else begin
						// fetch the next word while this one leaves
						cmd.issue = 1'b1;
						state_d   = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/ctc_dp.sv
module ctc_dp
	import ctc_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  in_word_t            in_data,
	input  logic [KEY_W-1:0]    key_chars,
	input  logic [KEYLEN_W-1:0] key_length,
	input  ctc_cmd_t            cmd,
	output ctc_sts_t            sts,
	output out_word_t           out_data
);

	localparam int KEY_COLS = (MAX_COLUMNS < KEY_SLOTS) ? MAX_COLUMNS : KEY_SLOTS;
	localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
	localparam int AW       = $clog2(DEPTH);
	localparam int CNTW     = $clog2(DEPTH + 1);
	localparam int LW       = $clog2(KEY_COLS + 1);
	localparam int CW       = $clog2(KEY_COLS);
	localparam int RW       = $clog2(MAX_ROWS + 1);

	logic [CNTW-1:0] count_q;
	logic            ovf_q;
	logic            mode_q;
	logic [LW-1:0]   len_q;
	logic [CNTW-1:0] n_q;
	logic            trunc_q;
	logic [CNTW-1:0] acc_q;
	logic [RW-1:0]   rows_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   rank_q  [KEY_COLS];
	logic [CW-1:0]   order_q [KEY_COLS];
	logic            pad_s1;
	logic            last_s1;
	out_word_t       out_q;

	logic [LW-1:0]   eff_len;
	logic [CNTW-1:0] cap;
	logic [7:0]      key_j;
	logic [CW-1:0]   rank_cnt;
	logic [CW-1:0]   rank_new;
	logic [CNTW:0]   div_sum;
	logic            div_fits;
	logic            col_end;
	logic            row_end;
	logic [CNTW-1:0] idx;
	logic            store_we;
	logic [7:0]      ram_rdata;

	// effective key length: zero acts as one, saturate at the column limit
	always_comb begin
		if (key_length == '0) begin
			eff_len = LW'(1);
		end else if (key_length > KEYLEN_W'(KEY_COLS)) begin
			eff_len = LW'(KEY_COLS);
		end else begin
			eff_len = LW'(key_length);
		end
	end

	assign cap = CNTW'(MAX_ROWS) * CNTW'(eff_len);

	// rank of column col_q: lower keys, and equal keys at lower columns, go first
	always_comb begin
		key_j    = key_chars[8*col_q +: 8];
		rank_cnt = '0;
		for (int k = 0; k < KEY_COLS; k++) begin
			if ((LW'(k) < len_q) && ((key_chars[8*k +: 8] < key_j) ||
			    ((key_chars[8*k +: 8] == key_j) && (CW'(k) < col_q)))) begin
				rank_cnt = rank_cnt + 1'b1;
			end
		end
		rank_new = rank_cnt;
	end

	assign div_sum  = {1'b0, acc_q} + (CNTW+1)'(len_q);
	assign div_fits = div_sum <= {1'b0, n_q};

	assign col_end = col_q == CW'(len_q - 1'b1);
	assign row_end = row_q == RW'(rows_q - 1'b1);

	// encrypt walks a column top to bottom, decrypt rebuilds a row from column runs
	always_comb begin
		if (!mode_q) begin
			idx = CNTW'(row_q) * CNTW'(len_q) + CNTW'(order_q[col_q]);
		end else begin
			idx = CNTW'(rank_q[col_q]) * CNTW'(rows_q) + CNTW'(row_q);
		end
	end

	assign store_we = cmd.take && (count_q < CNTW'(DEPTH));

	ctc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[AW-1:0]),
		.wdata(in_data.data_in),
		.re   (cmd.issue),
		.raddr(idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			mode_q  <= 1'b0;
			len_q   <= LW'(1);
			n_q     <= '0;
			trunc_q <= 1'b0;
			acc_q   <= '0;
			rows_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cmd.take) begin
				if (count_q == '0 && !ovf_q) begin
					mode_q <= in_data.mode;
				end
				if (count_q < CNTW'(DEPTH)) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.setup) begin
				len_q   <= eff_len;
				n_q     <= (count_q > cap) ? cap : count_q;
				trunc_q <= ovf_q || (count_q > cap);
				count_q <= '0;
				ovf_q   <= 1'b0;
				acc_q   <= '0;
				rows_q  <= '0;
				col_q   <= '0;
				row_q   <= '0;
			end
			if (cmd.rank) begin
				col_q <= col_end ? '0 : col_q + 1'b1;
			end
			if (cmd.divide) begin
				if (div_fits) begin
					acc_q  <= div_sum[CNTW-1:0];
					rows_q <= rows_q + 1'b1;
				end else if (!mode_q && acc_q != n_q) begin
					// partial last row, padded on the way out
					rows_q <= rows_q + 1'b1;
				end
			end
			if (cmd.issue) begin
				if (!mode_q) begin
					if (row_end) begin
						row_q <= '0;
						col_q <= col_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					if (col_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rank) begin
			rank_q[col_q]     <= rank_new;
			order_q[rank_new] <= col_q;
		end
		if (cmd.issue) begin
			pad_s1  <= !mode_q && (idx >= n_q);
			last_s1 <= col_end && row_end;
		end
		if (cmd.load) begin
			out_q.data_out <= pad_s1 ? PAD_BYTE : ram_rdata;
			out_q.last_out <= last_s1;
			out_q.status   <= trunc_q ? STATUS_TRUNC : STATUS_OK;
		end else if (cmd.empty) begin
			out_q.data_out <= '0;
			out_q.last_out <= 1'b1;
			out_q.status   <= STATUS_EMPTY;
		end
	end

	assign sts.rank_done = col_end;
	assign sts.div_done  = !div_fits;
	assign sts.rows_zero = (rows_q == '0) && (mode_q || acc_q == n_q);
	assign sts.out_last  = out_q.last_out;
	assign out_data      = out_q;

endmodule

>>> rtl/columnar_transposition_cipher_core.sv
// Columnar transposition cipher. Message bytes are taken one per cycle while idle and
// kept in a byte store of MAX_ROWS*MAX_COLUMNS entries until the word marked last_in;
// the mode of the first word selects encrypt (rows of key_length bytes, space padded,
// read out by columns in ascending key order, ties to the lower column) or decrypt
// (whole rows only, columns refilled in key order, read out by rows). After the last
// word the core runs a setup step, ranks the key columns and finds the row count, then
// delivers the result words, each through a registered store read and then the output
// register, while out_stall is low. A new message is accepted once the final result
// word has been taken. Input past the store, or past MAX_ROWS rows, is dropped and
// every result word then carries status 1; a decrypt message with no full row instead
// gives one word of 0 with status 2.
module columnar_transposition_cipher_core
	import ctc_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [KEY_W-1:0]    key_chars_q;
	logic [KEYLEN_W-1:0] key_length_q;
	ctc_cmd_t            cmd;
	ctc_sts_t            sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q  <= '0;
			key_length_q <= KEYLEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_CHARS:  key_chars_q  <= cfg_data[KEY_W-1:0];
				CFG_KEY_LENGTH: key_length_q <= cfg_data[KEYLEN_W-1:0];
				default: ;
			endcase
		end
	end

	ctc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_in  (in_data.last_in),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ctc_dp #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.key_chars (key_chars_q),
		.key_length(key_length_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
